[src/quality_bin_run_length_encoder_unit_defines.svh]
// Assertion macros for the quality bin run-length encoder RTL.
`ifndef QUALITY_BIN_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH
`define QUALITY_BIN_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH

// Check that holds at every edge, reset included.
`define QBRLE_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) expr) else $error(msg);

// Check that is ignored while reset is asserted.
`define QBRLE_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) expr) else $error(msg);

`endif

[src/qbrle_pkg.sv]
// Shared types, constants and the bin mapping for the quality bin run-length encoder.
package qbrle_pkg;

	localparam int BIN_W = 3;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	localparam logic [7:0] TH_BIN7 = 8'd73;
	localparam logic [7:0] TH_BIN6 = 8'd68;
	localparam logic [7:0] TH_BIN5 = 8'd63;
	localparam logic [7:0] TH_BIN4 = 8'd58;
	localparam logic [7:0] TH_BIN3 = 8'd53;
	localparam logic [7:0] TH_BIN2 = 8'd43;
	localparam logic [7:0] TH_BIN1 = 8'd35;

	// Queue between front and back; depth must stay a power of two.
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W = $clog2(Q_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} entry_t;

	typedef struct packed {
		logic [1:0] n;
		entry_t     e0;
		entry_t     e1;
	} push_t;

	typedef struct packed {
		logic not_empty;
		logic no_room;
	} q_stat_t;

	function automatic logic [BIN_W-1:0] bin_of(input logic [7:0] q);
		logic [BIN_W-1:0] b;
		if (q >= TH_BIN7)      b = 3'd7;
		else if (q >= TH_BIN6) b = 3'd6;
		else if (q >= TH_BIN5) b = 3'd5;
		else if (q >= TH_BIN4) b = 3'd4;
		else if (q >= TH_BIN3) b = 3'd3;
		else if (q >= TH_BIN2) b = 3'd2;
		else if (q >= TH_BIN1) b = 3'd1;
		else                   b = 3'd0;
		return b;
	endfunction

endpackage

[src/qbrle_front.sv]
// Front end: accepts quality characters, bins them and tracks the open run.
module qbrle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          quality,
	input  logic                last,
	input  qbrle_pkg::q_stat_t  q_stat,
	output qbrle_pkg::push_t    push
);

	logic [qbrle_pkg::BIN_W-1:0] run_bin_q;
	logic [qbrle_pkg::CNT_W-1:0] run_cnt_q;
	logic                        run_open_q;

	logic                        accept;
	logic [qbrle_pkg::BIN_W-1:0] b;
	logic                        close_old;
	logic                        cont;
	logic                        full;
	logic [qbrle_pkg::BIN_W-1:0] new_bin;
	logic [qbrle_pkg::CNT_W-1:0] new_cnt;

	assign in_stall = q_stat.no_room;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		b         = qbrle_pkg::bin_of(quality);
		close_old = run_open_q && (b != run_bin_q);
		cont      = run_open_q && (b == run_bin_q);
		new_bin   = cont ? run_bin_q : b;
		new_cnt   = cont ? run_cnt_q + 1'b1 : '0;
		full      = cont && (new_cnt == qbrle_pkg::CNT_MAX);

		push.e0.bin  = close_old ? run_bin_q : new_bin;
		push.e0.cnt  = close_old ? run_cnt_q : new_cnt;
		push.e0.last = close_old ? 1'b0 : last;
		push.e1.bin  = new_bin;
		push.e1.cnt  = new_cnt;
		push.e1.last = 1'b1;

		if (!accept)
			push.n = 2'd0;
		else if (close_old)
			push.n = last ? 2'd2 : 2'd1;
		else
			push.n = (full || last) ? 2'd1 : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_bin_q  <= '0;
			run_cnt_q  <= '0;
			run_open_q <= 1'b0;
		end else if (accept) begin
			// a full run or the end of a string leaves nothing pending
			run_open_q <= !(last || full);
			run_bin_q  <= last ? '0 : new_bin;
			run_cnt_q  <= last ? '0 : new_cnt;
		end
	end

endmodule

[src/qbrle_queue.sv]
// Short code queue: takes up to two entries per cycle, gives one.
`include "quality_bin_run_length_encoder_unit_defines.svh"

module qbrle_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  qbrle_pkg::push_t    push,
	input  logic                pop,
	output qbrle_pkg::entry_t   head,
	output qbrle_pkg::q_stat_t  q_stat
);

	qbrle_pkg::entry_t entries_q [qbrle_pkg::Q_DEPTH];

	logic [qbrle_pkg::QPTR_W-1:0] wptr_q;
	logic [qbrle_pkg::QPTR_W-1:0] rptr_q;
	logic [qbrle_pkg::QCNT_W-1:0] cnt_q;

	assign head             = entries_q[rptr_q];
	assign q_stat.not_empty = (cnt_q != '0);
	// need room for a two-entry transaction before taking an item
	assign q_stat.no_room   = (cnt_q > qbrle_pkg::QCNT_W'(qbrle_pkg::Q_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			entries_q[wptr_q] <= push.e0;
		if (push.n == 2'd2)
			entries_q[wptr_q + 1'b1] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + qbrle_pkg::QPTR_W'(push.n);
			rptr_q <= rptr_q + qbrle_pkg::QPTR_W'(pop);
			cnt_q  <= cnt_q + qbrle_pkg::QCNT_W'(push.n) - qbrle_pkg::QCNT_W'(pop);
		end
	end

	`QBRLE_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= qbrle_pkg::QCNT_W'(qbrle_pkg::Q_DEPTH), "queue overfilled")
	`QBRLE_ASSERT(a_pop_nonempty, pop |-> cnt_q != '0, "pop from empty queue")
	`QBRLE_ASSERT(a_push_room, (push.n != 2'd0) |-> !q_stat.no_room, "push without room")

endmodule

[src/qbrle_back.sv]
// Back end: drains the code queue into the registered output channel.
module qbrle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  qbrle_pkg::entry_t   head,
	input  qbrle_pkg::q_stat_t  q_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          code,
	output logic                last_res
);

	logic       out_valid_q;
	logic [7:0] code_q;
	logic       last_res_q;

	// advance when the output slot is free or its transaction completes
	assign pop = q_stat.not_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || !out_stall)
			out_valid_q <= q_stat.not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q     <= {head.bin, head.cnt};
			last_res_q <= head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign code      = code_q;
	assign last_res  = last_res_q;

endmodule

[src/quality_bin_run_length_encoder_unit.sv]
// Top level of the quality bin run-length encoder.
// Takes one quality character per cycle unless stalled and emits run-length code bytes (bin
// in bits 7..5, run length minus one in bits 4..0), closing a run on a bin change, at 32
// symbols, or on the character flagged last, whose final byte carries last_res. The front end
// bins and counts combinationally and writes zero, one or two codes into a four-entry queue;
// the back end moves one code per cycle, when out_stall allows, into the output register, and
// the output port sets the sustained rate: one item per cycle while items average at most one
// code, with input stall raised whenever the queue has fewer than two free entries.
module quality_bin_run_length_encoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] quality,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] code,
	output logic       last_res
);

	qbrle_pkg::push_t   push;
	qbrle_pkg::q_stat_t q_stat;
	qbrle_pkg::entry_t  head;
	logic               pop;

	qbrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.quality  (quality),
		.last     (last),
		.q_stat   (q_stat),
		.push     (push)
	);

	qbrle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	qbrle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code      (code),
		.last_res  (last_res)
	);

endmodule

[bench/quality_bin_run_length_encoder_unit_tb.sv]
// Self-checking testbench for the quality bin run-length encoder unit.
module quality_bin_run_length_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_GOAL = 1050;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [7:0] EDGE_Q [17] = '{
		8'd1, 8'd34, 8'd35, 8'd42, 8'd43, 8'd52, 8'd53, 8'd57, 8'd58,
		8'd62, 8'd63, 8'd67, 8'd68, 8'd72, 8'd73, 8'd255, 8'd255
	};

	typedef struct packed {
		logic [7:0] code;
		logic       last_res;
	} code_byte_t;

	class rle_scoreboard;
		code_byte_t                  codes_due[$];
		logic [qbrle_pkg::BIN_W-1:0] run_bin;
		logic [qbrle_pkg::CNT_W-1:0] run_count;
		bit                          run_open;
		int                          errors;

		function new();
			run_bin = '0;
			run_count = '0;
			run_open = 1'b0;
			errors = 0;
		endfunction

		// Thresholds rise monotonically, so the bin is the number passed.
		function logic [qbrle_pkg::BIN_W-1:0] bin_for(logic [7:0] q);
			logic [qbrle_pkg::BIN_W-1:0] b;
			b = '0;
			if (q >= qbrle_pkg::TH_BIN1) b++;
			if (q >= qbrle_pkg::TH_BIN2) b++;
			if (q >= qbrle_pkg::TH_BIN3) b++;
			if (q >= qbrle_pkg::TH_BIN4) b++;
			if (q >= qbrle_pkg::TH_BIN5) b++;
			if (q >= qbrle_pkg::TH_BIN6) b++;
			if (q >= qbrle_pkg::TH_BIN7) b++;
			return b;
		endfunction

		function void close_run();
			codes_due.push_back('{code: {run_bin, run_count}, last_res: 1'b0});
			run_open = 1'b0;
		endfunction

		function void note_quality(logic [7:0] q, logic l);
			logic [qbrle_pkg::BIN_W-1:0] b;
			b = bin_for(q);
			if (run_open && b != run_bin)
				close_run();
			if (run_open) begin
				run_count++;
			end else begin
				run_bin = b;
				run_count = '0;
				run_open = 1'b1;
			end
			if (run_count == qbrle_pkg::CNT_MAX)
				close_run();
			// Flush the pending run and mark the final byte of the string.
			if (l) begin
				if (run_open)
					close_run();
				codes_due[codes_due.size()-1].last_res = 1'b1;
				run_bin = '0;
				run_count = '0;
			end
		endfunction

		function void check_code(logic [7:0] c, logic lr);
			code_byte_t want;
			if (codes_due.size() == 0) begin
				$display("%0t: unexpected code byte: expected none, got %02h last_res %0b",
					$time, c, lr);
				errors++;
				return;
			end
			want = codes_due.pop_front();
			if (want.code !== c) begin
				$display("%0t: code mismatch: expected %02h, got %02h", $time, want.code, c);
				errors++;
			end
			if (want.last_res !== lr) begin
				$display("%0t: last_res mismatch: expected %0b, got %0b",
					$time, want.last_res, lr);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] quality;
	logic       last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] code;
	logic       last_res;

	rle_scoreboard sb;
	int  tx_idle_pct;
	int  rx_idle_pct;
	int  items_sent = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;

	quality_bin_run_length_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.quality   (quality),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code      (code),
		.last_res  (last_res)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] quality_in_bin(logic [qbrle_pkg::BIN_W-1:0] b);
		logic [7:0] q;
		case (b)
			3'd0: q = 8'($urandom_range(qbrle_pkg::TH_BIN1 - 1, 1));
			3'd1: q = 8'($urandom_range(qbrle_pkg::TH_BIN2 - 1, qbrle_pkg::TH_BIN1));
			3'd2: q = 8'($urandom_range(qbrle_pkg::TH_BIN3 - 1, qbrle_pkg::TH_BIN2));
			3'd3: q = 8'($urandom_range(qbrle_pkg::TH_BIN4 - 1, qbrle_pkg::TH_BIN3));
			3'd4: q = 8'($urandom_range(qbrle_pkg::TH_BIN5 - 1, qbrle_pkg::TH_BIN4));
			3'd5: q = 8'($urandom_range(qbrle_pkg::TH_BIN6 - 1, qbrle_pkg::TH_BIN5));
			3'd6: q = 8'($urandom_range(qbrle_pkg::TH_BIN7 - 1, qbrle_pkg::TH_BIN6));
			default: q = 8'($urandom_range(255, qbrle_pkg::TH_BIN7));
		endcase
		return q;
	endfunction

	// Call at a rising edge; returns at the edge that accepts the transaction.
	task automatic send_item(input logic [7:0] q, input logic l);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		quality <= q;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_quality(q, l);
		items_sent++;
	endtask

	// A string of runs: mostly short runs, some around the 32-symbol limit,
	// and now and then pure noise with no run structure.
	task automatic send_string();
		int                          n_runs;
		int                          run_len;
		int                          pick;
		bit                          noisy;
		logic [qbrle_pkg::BIN_W-1:0] b;
		n_runs = $urandom_range(4, 1);
		noisy = ($urandom_range(9) == 0);
		for (int r = 0; r < n_runs; r++) begin
			b = qbrle_pkg::BIN_W'($urandom_range(7));
			pick = $urandom_range(9);
			if (pick < 6)
				run_len = $urandom_range(4, 1);
			else if (pick < 9)
				run_len = $urandom_range(34, 30);
			else
				run_len = $urandom_range(70, 5);
			for (int i = 0; i < run_len; i++)
				send_item(noisy ? 8'($urandom) : quality_in_bin(b),
					r == n_runs - 1 && i == run_len - 1);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_code(code, last_res);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d code bytes outstanding", $time, sb.codes_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int phase_end;
		in_valid = 1'b0;
		quality = '0;
		last = 1'b0;
		out_stall = 1'b0;
		arst_n = 1'b1;
		sb = new();
		tx_idle_pct = 14;
		rx_idle_pct = 72;
		// give the reset a clean falling edge before the first clock
		#1 arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// quality zero as a one-character string
		send_item(8'd0, 1'b1);
		// walk every bin boundary, then flush a three-symbol run
		foreach (EDGE_Q[i])
			send_item(EDGE_Q[i], i == 16);
		// bin change on the last character gives two bytes
		send_item(8'd40, 1'b0);
		send_item(8'd100, 1'b1);
		// last character completes a full run
		for (int i = 0; i < 32; i++)
			send_item(quality_in_bin(3'd4), i == 31);

		for (int p = 0; p < 3; p++) begin
			tx_idle_pct = (p == 0) ? 14 : (p == 1) ? 72 : 0;
			rx_idle_pct = (p == 0) ? 72 : (p == 1) ? 14 : 0;
			// hold the output so the queue fills and input stall rises
			if (p != 1)
				hold_req = 1'b1;
			phase_end = ITEM_GOAL * (p + 1) / 3;
			while (items_sent < phase_end)
				send_string();
		end
		in_valid <= 1'b0;

		while (sb.codes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
